// File: hdl/wcc_pkg.sv
`timescale 1ns / 1ps

package wcc_pkg;

    localparam int DEF_MAX_PAIRS  = 8;
    localparam int DEF_MARKER_MAX = 8;

    localparam int CHAR_W    = 8;
    localparam int REG_W     = 64;
    localparam int LEN_W     = 4;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_FROM_CHARS    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TO_CHARS      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PAIR_COUNT    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_AFTER_MARKER  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_AFTER_LEN     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_BEFORE_MARKER = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_BEFORE_LEN    = 3'd6;

    // one released byte on its way to the back end
    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              conv;
        logic              last;
    } wcc_item_t;

    typedef struct packed {
        logic [REG_W-1:0] after_marker;
        logic [LEN_W-1:0] after_len;
        logic [REG_W-1:0] before_marker;
        logic [LEN_W-1:0] before_len;
    } wcc_front_cfg_t;

    typedef struct packed {
        logic [REG_W-1:0] from_chars;
        logic [REG_W-1:0] to_chars;
        logic [LEN_W-1:0] pair_count;
    } wcc_back_cfg_t;

endpackage

// File: hdl/wcc_front.sv
`timescale 1ns / 1ps

module wcc_front
    import wcc_pkg::*;
#(
    parameter int MARKER_MAX = DEF_MARKER_MAX
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  wcc_front_cfg_t    cfg,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [CHAR_W-1:0] in_char,
    input  logic              in_last,
    output logic              o_valid,
    input  logic              o_ready,
    output wcc_item_t         o_item
);

    localparam int DEPTH  = 2 * MARKER_MAX;
    localparam int CW     = $clog2(DEPTH + 1);
    localparam int FW     = $clog2(MARKER_MAX + 1);
    localparam int HIST_W = CHAR_W * MARKER_MAX;

    logic [HIST_W-1:0] hist_reg, hist_next;
    logic [FW-1:0]     fill_reg, fill_next;
    logic              aseen_reg, aseen_next;
    logic              bseen_reg, bseen_next;
    logic [CW-1:0]     total_reg, total_next;
    logic [CW-1:0]     rel_reg, rel_next;

    logic [CHAR_W-1:0] q_ch_reg   [DEPTH];
    logic              q_open_reg [DEPTH];
    logic              q_last_reg [DEPTH];
    logic [CHAR_W-1:0] q_ch_next  [DEPTH];
    logic              q_open_next[DEPTH];
    logic              q_last_next[DEPTH];

    logic [HIST_W+CHAR_W-1:0] hist_cat;
    logic [HIST_W-1:0]        hist_n;
    logic [FW-1:0]            fill_n;
    logic [LEN_W-1:0]         alen, blen, keep;
    logic                     ahit, bhit, open_now, clr;
    logic                     take, drain;
    logic [CW-1:0]            total_in, hcnt, hinc, keepc, new_held;

    function automatic logic marker_hit(
        input logic [HIST_W-1:0] hist,
        input logic [REG_W-1:0]  marker,
        input logic [LEN_W-1:0]  len,
        input logic [FW-1:0]     fill
    );
        logic hit;
        logic ok;
        hit = 1'b0;
        for (int l = 1; l <= MARKER_MAX; l++) begin
            ok = 1'b1;
            for (int i = 0; i < l; i++) begin
                if (hist[CHAR_W*(MARKER_MAX-l+i) +: CHAR_W] != marker[CHAR_W*i +: CHAR_W])
                    ok = 1'b0;
            end
            if (len == LEN_W'(l) && LEN_W'(fill) >= len)
                hit = ok;
        end
        return hit;
    endfunction

    assign take     = in_valid && in_ready;
    assign drain    = (rel_reg != '0) && o_ready;
    assign in_ready = (total_reg < CW'(DEPTH));
    assign o_valid  = (rel_reg != '0);
    assign o_item   = '{ch: q_ch_reg[0], conv: q_open_reg[0], last: q_last_reg[0]};

    always_comb begin
        hist_cat = {in_char, hist_reg};
        hist_n   = hist_cat[HIST_W+CHAR_W-1:CHAR_W];
        fill_n   = (fill_reg == FW'(MARKER_MAX)) ? fill_reg : fill_reg + FW'(1);

        alen = (cfg.after_len > LEN_W'(MARKER_MAX)) ? LEN_W'(MARKER_MAX) : cfg.after_len;
        blen = (cfg.before_len > LEN_W'(MARKER_MAX)) ? LEN_W'(MARKER_MAX) : cfg.before_len;
        keep = (blen != '0) ? blen - LEN_W'(1) : '0;

        open_now = (alen == '0) || aseen_reg;
        ahit = !aseen_reg && marker_hit(hist_n, cfg.after_marker, alen, fill_n);
        bhit = !bseen_reg && marker_hit(hist_n, cfg.before_marker, blen, fill_n);
        clr  = take && (bseen_reg || bhit);

        hcnt     = total_reg - rel_reg;
        hinc     = hcnt + CW'(1);
        keepc    = CW'(keep);
        new_held = (in_last || bseen_reg || bhit) ? '0 :
                   ((hinc < keepc) ? hinc : keepc);
        total_in = total_reg - CW'(drain);

        total_next = total_in;
        rel_next   = rel_reg - CW'(drain);
        hist_next  = hist_reg;
        fill_next  = fill_reg;
        aseen_next = aseen_reg;
        bseen_next = bseen_reg;

        if (take) begin
            total_next = total_in + CW'(1);
            rel_next   = total_in + CW'(1) - new_held;
            if (in_last) begin
                hist_next  = '0;
                fill_next  = '0;
                aseen_next = 1'b0;
                bseen_next = 1'b0;
            end else begin
                hist_next  = hist_n;
                fill_next  = fill_n;
                aseen_next = aseen_reg || ahit;
                bseen_next = bseen_reg || bhit;
            end
        end

        for (int i = 0; i < DEPTH; i++) begin
            if (drain && i < DEPTH - 1) begin
                q_ch_next[i]   = q_ch_reg[(i+1) % DEPTH];
                q_last_next[i] = q_last_reg[(i+1) % DEPTH];
                q_open_next[i] = q_open_reg[(i+1) % DEPTH] &&
                                 !(clr && CW'(i + 1) >= rel_reg);
            end else begin
                q_ch_next[i]   = q_ch_reg[i];
                q_last_next[i] = q_last_reg[i];
                q_open_next[i] = q_open_reg[i] && !(clr && CW'(i) >= rel_reg);
            end
            if (take && CW'(i) == total_in) begin
                q_ch_next[i]   = in_char;
                q_last_next[i] = in_last;
                q_open_next[i] = open_now && !clr;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hist_reg  <= '0;
            fill_reg  <= '0;
            aseen_reg <= 1'b0;
            bseen_reg <= 1'b0;
            total_reg <= '0;
            rel_reg   <= '0;
        end else begin
            hist_reg  <= hist_next;
            fill_reg  <= fill_next;
            aseen_reg <= aseen_next;
            bseen_reg <= bseen_next;
            total_reg <= total_next;
            rel_reg   <= rel_next;
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < DEPTH; i++) begin
            q_ch_reg[i]   <= q_ch_next[i];
            q_open_reg[i] <= q_open_next[i];
            q_last_reg[i] <= q_last_next[i];
        end
    end

endmodule

// File: hdl/wcc_fifo.sv
`timescale 1ns / 1ps

module wcc_fifo #(
    parameter int WIDTH = 10
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [WIDTH-1:0] in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [WIDTH-1:0] out_data
);

    logic [WIDTH-1:0] d0_reg, d0_next;
    logic [WIDTH-1:0] d1_reg, d1_next;
    logic [1:0]       cnt_reg, cnt_next;
    logic             push, pop;

    assign in_ready  = (cnt_reg != 2'd2);
    assign out_valid = (cnt_reg != 2'd0);
    assign out_data  = d0_reg;
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb begin
        cnt_next = cnt_reg + 2'(push) - 2'(pop);
        d0_next  = d0_reg;
        d1_next  = d1_reg;
        if (pop) begin
            d0_next = (cnt_reg == 2'd2) ? d1_reg : in_data;
        end else if (push && cnt_reg == 2'd0) begin
            d0_next = in_data;
        end
        if (push && cnt_reg == 2'd1 && !pop) begin
            d1_next = in_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 2'd0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        d0_reg <= d0_next;
        d1_reg <= d1_next;
    end

endmodule

// File: hdl/wcc_back.sv
`timescale 1ns / 1ps

module wcc_back
    import wcc_pkg::*;
#(
    parameter int MAX_PAIRS = DEF_MAX_PAIRS
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  wcc_back_cfg_t     cfg,
    input  logic              in_valid,
    output logic              in_ready,
    input  wcc_item_t         in_item,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [CHAR_W-1:0] m_tdata,
    output logic              m_tlast
);

    logic              tvalid_reg, tvalid_next;
    logic [CHAR_W-1:0] tdata_reg;
    logic              tlast_reg;
    logic [CHAR_W-1:0] xlat;
    logic [LEN_W-1:0]  pcnt;
    logic              found, load;

    assign in_ready = !tvalid_reg || m_tready;
    assign load     = in_valid && in_ready;
    assign m_tvalid = tvalid_reg;
    assign m_tdata  = tdata_reg;
    assign m_tlast  = tlast_reg;

    // first matching pair wins
    always_comb begin
        pcnt  = (cfg.pair_count > LEN_W'(MAX_PAIRS)) ? LEN_W'(MAX_PAIRS) : cfg.pair_count;
        xlat  = in_item.ch;
        found = 1'b0;
        for (int k = 0; k < MAX_PAIRS; k++) begin
            if (!found && LEN_W'(k) < pcnt &&
                cfg.from_chars[CHAR_W*k +: CHAR_W] == in_item.ch) begin
                found = 1'b1;
                xlat  = cfg.to_chars[CHAR_W*k +: CHAR_W];
            end
        end
        tvalid_next = load ? 1'b1 : (tvalid_reg && !m_tready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tvalid_reg <= 1'b0;
        end else begin
            tvalid_reg <= tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            tdata_reg <= in_item.conv ? xlat : in_item.ch;
            tlast_reg <= in_item.last;
        end
    end

endmodule

// File: hdl/windowed_char_converter_core.sv
`timescale 1ns / 1ps

// Windowed character converter.
// Input stream s_*: one byte per word, tlast on the final byte of a field.
// Output stream m_*: the same bytes in the same order, those inside the
// window translated through the first matching from/to pair; tlast stays
// on the field's final byte.
// Config channel cfg_*: index 0..6 selects from_chars, to_chars, pair_count,
// after_marker, after_len, before_marker, before_len; cfg_ready is always
// high. Write only while no field is in flight.
// While m_tready is high, bytes go in and out one per cycle, and so do the
// held bytes that the final byte releases. A byte passes the front queue,
// the two-word queue and the output register, and waits for the before_len-1
// later bytes while a BEFORE match is still possible. The front queue holds
// 2*MARKER_MAX bytes, so the next field is taken while the last one drains.
// Reset clears the config registers and all per-field state.
// When m_tready is low, results back up through the output register and a
// two-word queue into the front queue; s_tready drops once that is full.

module windowed_char_converter_core
    import wcc_pkg::*;
#(
    parameter int MAX_PAIRS  = DEF_MAX_PAIRS,
    parameter int MARKER_MAX = DEF_MARKER_MAX
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [REG_W-1:0]     cfg_data,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [CHAR_W-1:0]    s_tdata,   // [7:0] in_char
    input  logic                 s_tlast,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [CHAR_W-1:0]    m_tdata,   // [7:0] out_char
    output logic                 m_tlast
);

    localparam int ITEM_W = $bits(wcc_item_t);

    wcc_front_cfg_t fcfg_reg;
    wcc_back_cfg_t  bcfg_reg;
    logic           wr;

    logic      f_valid, f_ready, b_valid, b_ready;
    wcc_item_t f_item, b_item;

    assign cfg_ready = 1'b1;
    assign wr        = cfg_valid && cfg_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fcfg_reg <= '0;
            bcfg_reg <= '0;
        end else if (wr) begin
            case (cfg_index)
                CFG_FROM_CHARS:    bcfg_reg.from_chars    <= cfg_data;
                CFG_TO_CHARS:      bcfg_reg.to_chars      <= cfg_data;
                CFG_PAIR_COUNT:    bcfg_reg.pair_count    <= cfg_data[LEN_W-1:0];
                CFG_AFTER_MARKER:  fcfg_reg.after_marker  <= cfg_data;
                CFG_AFTER_LEN:     fcfg_reg.after_len     <= cfg_data[LEN_W-1:0];
                CFG_BEFORE_MARKER: fcfg_reg.before_marker <= cfg_data;
                CFG_BEFORE_LEN:    fcfg_reg.before_len    <= cfg_data[LEN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    wcc_front #(
        .MARKER_MAX (MARKER_MAX)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (fcfg_reg),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_char  (s_tdata),
        .in_last  (s_tlast),
        .o_valid  (f_valid),
        .o_ready  (f_ready),
        .o_item   (f_item)
    );

    wcc_fifo #(
        .WIDTH (ITEM_W)
    ) u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_data   (f_item),
        .out_valid (b_valid),
        .out_ready (b_ready),
        .out_data  (b_item)
    );

    wcc_back #(
        .MAX_PAIRS (MAX_PAIRS)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (bcfg_reg),
        .in_valid (b_valid),
        .in_ready (b_ready),
        .in_item  (b_item),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

// File: verif/tb.sv
`timescale 1ns / 1ps

module tb;
    import wcc_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int LONG_HOLD      = 300;
    localparam int SETTLE_CYCLES  = 24;
    localparam int PHASE_WORDS    = 57;

    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              last;
    } char_word_t;

    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              in_window;
    } held_char_t;

    logic                 aclk;
    logic                 aresetn   = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [REG_W-1:0]     cfg_data  = '0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [CHAR_W-1:0]    s_tdata   = '0;
    logic                 s_tlast   = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [CHAR_W-1:0]    m_tdata;
    logic                 m_tlast;

    windowed_char_converter_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // stimulus side
    char_word_t bytes_to_send[$];
    int         words_queued  = 0;
    int         send_idle_pct = 0;
    int         recv_stall_pct = 0;
    int         rx_hold_req   = 0;
    bit         s_took        = 1'b0;
    int         fail_count    = 0;
    int         quiet_cycles  = 0;

    // register values as last written, for stimulus shaping
    logic [REG_W-1:0] plan_from, plan_amark, plan_bmark;
    logic [LEN_W-1:0] plan_pairs, plan_alen, plan_blen;

    // predictor: register shadow and per-field state
    logic [REG_W-1:0] conv_from   = '0;
    logic [REG_W-1:0] conv_to     = '0;
    logic [LEN_W-1:0] conv_pairs  = '0;
    logic [REG_W-1:0] after_mark  = '0;
    logic [LEN_W-1:0] after_mlen  = '0;
    logic [REG_W-1:0] before_mark = '0;
    logic [LEN_W-1:0] before_mlen = '0;

    logic [63:0] recent_bytes = '0;
    int          bytes_seen   = 0;
    bit          after_found  = 1'b0;
    bit          before_found = 1'b0;
    held_char_t  held_q[$];
    char_word_t  awaited_bytes[$];

    task automatic report_mismatch(string msg);
        if (fail_count < 50)
            $display("MISMATCH at %0t: %s", $time, msg);
        fail_count++;
    endtask

    function automatic int sat8(logic [LEN_W-1:0] v);
        return (v > 8) ? 8 : int'(v);
    endfunction

    function automatic bit tail_matches(logic [63:0] marker, int len);
        logic [63:0] mask;
        logic [63:0] tail;
        if (len == 0 || bytes_seen < len)
            return 1'b0;
        tail = recent_bytes >> (64 - 8 * len);
        mask = (len == 8) ? '1 : ((64'd1 << (8 * len)) - 64'd1);
        return (tail & mask) == (marker & mask);
    endfunction

    // first matching pair wins, no re-translation
    function automatic logic [7:0] convert_char(logic [7:0] c);
        int n;
        n = sat8(conv_pairs);
        for (int k = 0; k < n; k++) begin
            if (conv_from[8*k +: 8] == c)
                return conv_to[8*k +: 8];
        end
        return c;
    endfunction

    task automatic release_held(logic last);
        held_char_t h;
        char_word_t w;
        h = held_q.pop_front();
        w.ch = (h.in_window && !before_found) ? convert_char(h.ch) : h.ch;
        w.last = last;
        awaited_bytes.push_back(w);
    endtask

    task automatic predict_word(logic [7:0] c, logic last);
        int         alen;
        int         blen;
        int         keep;
        bit         in_window;
        held_char_t h;
        char_word_t w;
        alen = sat8(after_mlen);
        blen = sat8(before_mlen);
        keep = (blen > 0) ? blen - 1 : 0;
        recent_bytes = {c, recent_bytes[63:8]};
        if (bytes_seen < 8)
            bytes_seen++;
        in_window = (alen == 0) || after_found;
        if (!after_found && tail_matches(after_mark, alen))
            after_found = 1'b1;
        if (before_found || tail_matches(before_mark, blen)) begin
            before_found = 1'b1;
            while (held_q.size() > 0)
                release_held(1'b0);
            w.ch = c;
            w.last = last;
            awaited_bytes.push_back(w);
        end else begin
            if (held_q.size() >= 8)
                release_held(1'b0);
            h.ch = c;
            h.in_window = in_window;
            held_q.push_back(h);
            if (last) begin
                while (held_q.size() > 0)
                    release_held(held_q.size() == 1);
            end else begin
                while (held_q.size() > keep)
                    release_held(1'b0);
            end
        end
        if (last) begin
            recent_bytes = '0;
            bytes_seen = 0;
            after_found = 1'b0;
            before_found = 1'b0;
            held_q.delete();
        end
    endtask

    // monitor: register shadow, prediction on input words, output check
    always @(posedge aclk) begin
        s_took = aresetn && s_tvalid && s_tready;
        if (aresetn) begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_FROM_CHARS:    conv_from   = cfg_data;
                    CFG_TO_CHARS:      conv_to     = cfg_data;
                    CFG_PAIR_COUNT:    conv_pairs  = cfg_data[LEN_W-1:0];
                    CFG_AFTER_MARKER:  after_mark  = cfg_data;
                    CFG_AFTER_LEN:     after_mlen  = cfg_data[LEN_W-1:0];
                    CFG_BEFORE_MARKER: before_mark = cfg_data;
                    CFG_BEFORE_LEN:    before_mlen = cfg_data[LEN_W-1:0];
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) begin
                if (awaited_bytes.size() == 0) begin
                    report_mismatch($sformatf("unexpected word %h last %b", m_tdata, m_tlast));
                end else begin
                    if (m_tdata !== awaited_bytes[0].ch)
                        report_mismatch($sformatf("out_char %h, expected %h",
                                                  m_tdata, awaited_bytes[0].ch));
                    if (m_tlast !== awaited_bytes[0].last)
                        report_mismatch($sformatf("out_last %b, expected %b (char %h)",
                                                  m_tlast, awaited_bytes[0].last,
                                                  awaited_bytes[0].ch));
                    void'(awaited_bytes.pop_front());
                end
            end
            if (s_tvalid && s_tready)
                predict_word(s_tdata, s_tlast);
        end
    end

    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_took) begin
            if (bytes_to_send.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                s_tvalid <= 1'b1;
                s_tdata  <= bytes_to_send[0].ch;
                s_tlast  <= bytes_to_send[0].last;
                void'(bytes_to_send.pop_front());
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    int rx_hold_seen = 0;
    int rx_hold_left = 0;

    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (rx_hold_left > 0) begin
            rx_hold_left--;
            m_tready <= 1'b0;
        end else if (rx_hold_seen != rx_hold_req) begin
            rx_hold_seen = rx_hold_req;
            rx_hold_left = LONG_HOLD;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic add_word(logic [7:0] c, logic last);
        char_word_t w;
        w.ch = c;
        w.last = last;
        bytes_to_send.push_back(w);
        words_queued++;
    endtask

    task automatic queue_text(string s);
        for (int i = 0; i < s.len(); i++)
            add_word(s[i], i == s.len() - 1);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [REG_W-1:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    task automatic apply_config(input logic [63:0] f, input logic [63:0] t,
                                input logic [3:0] pc, input logic [63:0] am,
                                input logic [3:0] al, input logic [63:0] bm,
                                input logic [3:0] bl);
        plan_from  = f;
        plan_pairs = pc;
        plan_amark = am;
        plan_alen  = al;
        plan_bmark = bm;
        plan_blen  = bl;
        write_reg(CFG_FROM_CHARS, f);
        write_reg(CFG_TO_CHARS, t);
        write_reg(CFG_PAIR_COUNT, {60'd0, pc});
        write_reg(CFG_AFTER_MARKER, am);
        write_reg(CFG_AFTER_LEN, {60'd0, al});
        write_reg(CFG_BEFORE_MARKER, bm);
        write_reg(CFG_BEFORE_LEN, {60'd0, bl});
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // held bytes may still be on their way after the last result
    task automatic wait_drained();
        while (bytes_to_send.size() > 0 || s_tvalid || awaited_bytes.size() > 0)
            @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    function automatic logic [7:0] pick_char();
        int r;
        r = $urandom_range(99);
        if (r < 15 && sat8(plan_pairs) > 0)
            return plan_from[8*$urandom_range(sat8(plan_pairs) - 1) +: 8];
        if (r < 30 && sat8(plan_alen) > 0)
            return plan_amark[8*$urandom_range(sat8(plan_alen) - 1) +: 8];
        if (r < 45 && sat8(plan_blen) > 0)
            return plan_bmark[8*$urandom_range(sat8(plan_blen) - 1) +: 8];
        return 8'($urandom_range(255));
    endfunction

    task automatic push_filler(ref logic [7:0] f[$]);
        repeat ($urandom_range(0, 4)) f.push_back(pick_char());
    endtask

    task automatic push_marker(ref logic [7:0] f[$], input logic [63:0] m, input int len);
        int n;
        n = ($urandom_range(99) < 15) ? len - 1 : len;
        for (int i = 0; i < n; i++)
            f.push_back(m[8*i +: 8]);
    endtask

    task automatic queue_random_field();
        logic [7:0] f[$];
        int         alen;
        int         blen;
        alen = sat8(plan_alen);
        blen = sat8(plan_blen);
        if ($urandom_range(99) < 20) begin
            repeat ($urandom_range(1, 24)) f.push_back(8'($urandom_range(255)));
        end else begin
            push_filler(f);
            if (alen > 0 && $urandom_range(99) < 75)
                push_marker(f, plan_amark, alen);
            push_filler(f);
            if (blen > 0 && $urandom_range(99) < 60)
                push_marker(f, plan_bmark, blen);
            push_filler(f);
            if (alen > 0 && $urandom_range(99) < 10)
                push_marker(f, plan_amark, alen);
            push_filler(f);
        end
        if (f.size() == 0)
            f.push_back(pick_char());
        foreach (f[i])
            add_word(f[i], i == f.size() - 1);
    endtask

    initial begin : stimulus
        logic [63:0] f, t, am, bm;
        logic [3:0]  pc, al, bl;
        int          start;

        repeat (12) @(posedge aclk);
        @(negedge aclk) aresetn <= 1'b1;

        // pairs: a->b, b->c, a->z (shadowed), 00->00, FF->FF
        apply_config(64'h0000_00FF_0061_6261, 64'h0000_00FF_007A_6362, 4'd5,
                     64'h3C3C, 4'd2, 64'h3E3E, 4'd2);
        @(posedge aclk);
        queue_text("xa<<ab>>ab");
        queue_text("ab");
        add_word(8'hFF, 1'b1);
        queue_text("<a<<b");
        wait_drained();

        apply_config(64'h0000_00FF_0061_6261, 64'h0000_00FF_007A_6362, 4'd8,
                     64'h3C3C, 4'd0, 64'h3E3E, 4'd0);
        @(posedge aclk);
        add_word(8'h00, 1'b0);
        add_word(8'hFF, 1'b0);
        add_word(8'h61, 1'b0);
        add_word(8'h62, 1'b0);
        add_word(8'h71, 1'b1);
        wait_drained();

        for (int p = 0; p < 8; p++) begin
            f  = {$urandom, $urandom};
            t  = {$urandom, $urandom};
            am = {$urandom, $urandom};
            bm = {$urandom, $urandom};
            case (p)
                0: begin pc = 4'd8;  al = 4'd1;  bl = 4'd1;  end
                1: begin pc = 4'd3;  al = 4'd2;  bl = 4'd3;  end
                2: begin pc = 4'd15; al = 4'd15; bl = 4'd15; end
                3: begin pc = 4'd0;  al = 4'd0;  bl = 4'd0;  end
                4: begin
                    pc = 4'($urandom_range(1, 8));
                    am = '0;
                    al = 4'd3;
                    bm = '1;
                    bl = 4'd8;
                end
                default: begin
                    pc = 4'($urandom_range(0, 15));
                    al = 4'($urandom_range(0, 4));
                    bl = 4'($urandom_range(0, 4));
                end
            endcase
            apply_config(f, t, pc, am, al, bm, bl);
            @(posedge aclk);
            case (p % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 68; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 68; end
                default: begin send_idle_pct = 22; recv_stall_pct = 22; end
            endcase
            if (p == 0)
                rx_hold_req++;
            start = words_queued;
            while (words_queued - start < PHASE_WORDS)
                queue_random_field();
            wait_drained();
        end

        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
